[design/tsccm_pkg.sv]
// ----------------------------------------------------------------------------
// tsccm_pkg - shared definitions for the continuity counter monitor
// Field widths, register indexes and reset values, fixed PIDs, event kinds
// and the structs that travel between the monitor's modules.
// ----------------------------------------------------------------------------
package tsccm_pkg;

   // field widths
   localparam int PID_W  = 13;
   localparam int CNT_W  = 4;
   localparam int CFG_W  = 16;
   localparam int CSR_AW = 3;

   // default size of the per-PID table
   localparam int PID_COUNT_DEF = 8192;

   // register indexes on the csr port
   localparam logic [CSR_AW-1:0] CSR_CHECK_ENABLE = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_NIT_PID      = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_PMT_PID      = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_PCR_PID      = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_EMM_PID      = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_ECM_PID      = 3'd5;

   // register reset values
   localparam logic [CFG_W-1:0] NIT_PID_RST = 16'h0010;
   localparam logic [CFG_W-1:0] PMT_PID_RST = 16'hffff;
   localparam logic [CFG_W-1:0] PCR_PID_RST = 16'hffff;
   localparam logic [CFG_W-1:0] EMM_PID_RST = 16'h0000;
   localparam logic [CFG_W-1:0] ECM_PID_RST = 16'h0000;

   // PIDs that are always known
   localparam logic [PID_W-1:0] PID_PAT  = 13'h0000;
   localparam logic [PID_W-1:0] PID_CAT  = 13'h0001;
   localparam logic [PID_W-1:0] PID_SDT  = 13'h0011;
   localparam logic [PID_W-1:0] PID_EIT  = 13'h0012;
   localparam logic [PID_W-1:0] PID_TDT  = 13'h0014;

   // kind of event reported for each packet
   typedef enum logic [1:0] {
      EV_IGNORED = 2'd0,
      EV_NEW     = 2'd1,
      EV_IN_SEQ  = 2'd2,
      EV_DISCONT = 2'd3
   } event_kind_type;

   // one table entry: seen flag and last counter
   typedef struct packed {
      logic             seen;
      logic [CNT_W-1:0] counter;
   } entry_type;

   // one result transaction
   typedef struct packed {
      event_kind_type   kind;
      logic [CNT_W-1:0] expected;
      logic [CNT_W-1:0] gap;
   } result_type;

   // configuration seen by the check logic
   typedef struct packed {
      logic             check_enable;
      logic [CFG_W-1:0] nit_pid;
      logic [CFG_W-1:0] pmt_pid;
      logic [CFG_W-1:0] pcr_pid;
      logic [CFG_W-1:0] emm_pid;
      logic [CFG_W-1:0] ecm_pid;
   } cfg_type;

endpackage

[design/tsccm_table.sv]
// ----------------------------------------------------------------------------
// tsccm_table - per-PID seen flag and counter store
// Single memory of seen/counter entries with a registered read port, a
// bypass from the same-cycle write, and a clearing pass after reset.
// ----------------------------------------------------------------------------
module tsccm_table
   import tsccm_pkg::*;
#(
   parameter int PID_COUNT = PID_COUNT_DEF,
   parameter int AW        = $clog2(PID_COUNT)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_entry,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_entry,
   output logic          ready
);

   entry_type     mem [PID_COUNT];
   entry_type     rd_ff, rd_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic          clr_busy_ff, clr_busy_in;

   // clearing pass sweeps every entry once after reset
   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(PID_COUNT - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   // memory write port, clear has priority
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
   end

   // registered read with bypass of the write in the same cycle
   always_comb begin
      rd_in = rd_ff;
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_in = wr_entry;
         end else begin
            rd_in = mem[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= rd_in;
   end

   assign rd_entry = rd_ff;
   assign ready    = ~clr_busy_ff;

endmodule

[design/tsccm_eval.sv]
// ----------------------------------------------------------------------------
// tsccm_eval - continuity check of one packet
// Decides known PID, compares the counter with the stored one and builds
// the result and the table update.
// ----------------------------------------------------------------------------
module tsccm_eval
   import tsccm_pkg::*;
(
   input  cfg_type          cfg,
   input  logic [PID_W-1:0] pid,
   input  logic [CNT_W-1:0] counter,
   input  logic             es_flag,
   input  logic             in_range,
   input  entry_type        entry,
   output result_type       result,
   output logic             wr_en,
   output entry_type        wr_entry
);

   logic [CFG_W-1:0] pid_ext;
   logic             fixed_hit;
   logic             cfg_hit;
   logic             known;
   logic [CNT_W-1:0] expect_cnt;

   assign pid_ext = CFG_W'(pid);

   // known PID test
   assign fixed_hit = (pid == PID_PAT) || (pid == PID_CAT) || (pid == PID_SDT) ||
                      (pid == PID_EIT) || (pid == PID_TDT);
   assign cfg_hit   = (pid_ext == cfg.nit_pid) || (pid_ext == cfg.pmt_pid) ||
                      (pid_ext == cfg.pcr_pid) || (pid_ext == cfg.emm_pid) ||
                      (pid_ext == cfg.ecm_pid);
   assign known     = es_flag || fixed_hit || cfg_hit;

   assign expect_cnt = entry.counter + CNT_W'(1);

   // classify and build the table update
   always_comb begin
      result           = '{kind: EV_IGNORED, expected: '0, gap: '0};
      wr_en            = 1'b0;
      wr_entry.seen    = 1'b1;
      wr_entry.counter = counter;
      if (cfg.check_enable && in_range) begin
         if (!entry.seen) begin
            if (known) begin
               result.kind = EV_NEW;
               wr_en       = 1'b1;
            end
         end else begin
            result.expected = expect_cnt;
            wr_en           = 1'b1;
            if ((counter == entry.counter) || (counter == expect_cnt)) begin
               result.kind = EV_IN_SEQ;
            end else begin
               result.kind = EV_DISCONT;
               result.gap  = counter - expect_cnt;
            end
         end
      end
   end

endmodule

[design/ts_continuity_counter_monitor.sv]
// ----------------------------------------------------------------------------
// ts_continuity_counter_monitor - per-PID continuity counter monitor
// Checks the continuity counter of each transport packet header against
// the last counter stored for its PID and reports one event per packet.
// ----------------------------------------------------------------------------
//  channel | direction | tdata (low bit up)                  | tuser
//  req     | in        | packet_pid[12:0], packet_counter    | in_program_stream
//  rsp     | out       | expected_counter, counter_gap       | event_kind
//  csr     | in        | write enable, index, 16-bit data    | -
//
// One packet per cycle sustained while rsp_tready stays high; a result is presented
// after its request passes the table read register and then the result register.
// The table read-modify-write is closed by a bypass on the read register.
// After reset a clearing pass over all PID_COUNT entries holds req_tready low.
// A stalled rsp side holds the check stage and then drops req_tready.
// ----------------------------------------------------------------------------
module ts_continuity_counter_monitor
   import tsccm_pkg::*;
#(
   parameter int PID_COUNT = PID_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // request: tdata = packet_pid[12:0], packet_counter[16:13], zero pad
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [23:0]       req_tdata,
   // request: tuser = in_program_stream
   input  logic              req_tuser,
   // response: tdata = expected_counter[3:0], counter_gap[7:4]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   // response: tuser = event_kind[1:0]
   output logic [1:0]        rsp_tuser,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [CFG_W-1:0]  csr_wdata
);

   localparam int AW = $clog2(PID_COUNT);

   cfg_type          cfg_ff, cfg_in;
   logic             s1_valid_ff, s1_valid_in;
   logic [PID_W-1:0] s1_pid_ff;
   logic [CNT_W-1:0] s1_cnt_ff;
   logic             s1_es_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_data_ff;

   logic             req_accept;
   logic             s1_advance;
   logic             table_ready;
   logic             s1_in_range;
   entry_type        rd_entry;
   result_type       eval_result;
   logic             eval_wr;
   entry_type        eval_wr_entry;
   logic [PID_W-1:0] req_pid;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_CHECK_ENABLE: cfg_in.check_enable = csr_wdata[0];
            CSR_NIT_PID:      cfg_in.nit_pid      = csr_wdata;
            CSR_PMT_PID:      cfg_in.pmt_pid      = csr_wdata;
            CSR_PCR_PID:      cfg_in.pcr_pid      = csr_wdata;
            CSR_EMM_PID:      cfg_in.emm_pid      = csr_wdata;
            CSR_ECM_PID:      cfg_in.ecm_pid      = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.check_enable <= 1'b0;
         cfg_ff.nit_pid      <= NIT_PID_RST;
         cfg_ff.pmt_pid      <= PMT_PID_RST;
         cfg_ff.pcr_pid      <= PCR_PID_RST;
         cfg_ff.emm_pid      <= EMM_PID_RST;
         cfg_ff.ecm_pid      <= ECM_PID_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // handshake control
   assign req_pid     = req_tdata[PID_W-1:0];
   assign s1_advance  = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = table_ready && (!s1_valid_ff || s1_advance);
   assign req_accept  = req_tvalid && req_tready;
   assign s1_in_range = ({1'b0, s1_pid_ff} < (PID_W + 1)'(PID_COUNT));

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // check stage payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pid_ff <= req_pid;
         s1_cnt_ff <= req_tdata[PID_W +: CNT_W];
         s1_es_ff  <= req_tuser;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_data_ff <= eval_result;
      end
   end

   tsccm_table #(
      .PID_COUNT (PID_COUNT),
      .AW        (AW)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_accept),
      .rd_addr  (req_pid[AW-1:0]),
      .rd_entry (rd_entry),
      .wr_en    (s1_advance && eval_wr),
      .wr_addr  (s1_pid_ff[AW-1:0]),
      .wr_entry (eval_wr_entry),
      .ready    (table_ready)
   );

   tsccm_eval u_eval (
      .cfg      (cfg_ff),
      .pid      (s1_pid_ff),
      .counter  (s1_cnt_ff),
      .es_flag  (s1_es_ff),
      .in_range (s1_in_range),
      .entry    (rd_entry),
      .result   (eval_result),
      .wr_en    (eval_wr),
      .wr_entry (eval_wr_entry)
   );

   // response outputs
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff.gap, rsp_data_ff.expected};
   assign rsp_tuser  = rsp_data_ff.kind;

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top - testbench for the continuity counter monitor
// Sends transport packet headers through the request stream and compares
// every event on the response stream with an in-bench predictor that keeps
// its own seen map, counter table and register copy. A directed opening
// covers the fixed and configured PIDs, wrap, repeat and discontinuity.
// Random phases then run counter sequences on a pool of live PIDs mixed
// with noise. Each phase uses a different register setting, and both
// stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
   import tsccm_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   // one packet header as the sender sees it
   typedef struct packed {
      logic [PID_W-1:0] pid;
      logic [CNT_W-1:0] cnt;
      logic             es;
   } ts_header_type;

   // a header together with the event it must produce
   typedef struct packed {
      ts_header_type hdr;
      result_type    ev;
   } cc_check_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [23:0]       req_tdata  = '0;
   logic              req_tuser  = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [7:0]        rsp_tdata;
   logic [1:0]        rsp_tuser;
   logic              csr_we     = 1'b0;
   logic [CSR_AW-1:0] csr_addr   = '0;
   logic [CFG_W-1:0]  csr_wdata  = '0;

   // predictor state: register copy, seen map and last counters
   cfg_type          model_cfg = '{check_enable: 1'b0, nit_pid: NIT_PID_RST,
                                   pmt_pid: PMT_PID_RST, pcr_pid: PCR_PID_RST,
                                   emm_pid: EMM_PID_RST, ecm_pid: ECM_PID_RST};
   bit               model_seen [PID_COUNT_DEF];
   bit [CNT_W-1:0]   last_cc    [PID_COUNT_DEF];

   // stimulus shaping: live PID pool and last counter sent per PID
   logic [PID_W-1:0] live_pids [$];
   bit               es_stream [PID_COUNT_DEF];
   bit [CNT_W-1:0]   sent_cc   [PID_COUNT_DEF];

   ts_header_type    headers_to_send [$];
   cc_check_type     cc_checks_due   [$];

   bit               no_idle = 1'b0;
   bit               hdr_pending = 1'b0;
   int               error_count = 0;
   int               packets_sent = 0;
   int               settings_used = 0;
   int               kind_seen [4];
   int               cycles = 0;

   ts_continuity_counter_monitor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // clock
   always #10 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles", cycles);
         $display("tb: failure");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("tb: mismatch at cycle %0d: %s", cycles, msg);
      error_count++;
   endtask

   // idle length: mostly none, some short, a few long
   function automatic int pick_idle();
      int r;
      if (no_idle)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // expected event for one accepted header; updates the predictor state
   function automatic result_type predict_cc_event(input ts_header_type h);
      result_type     ev;
      bit [CNT_W-1:0] last;
      bit             known;
      ev.kind     = EV_IGNORED;
      ev.expected = '0;
      ev.gap      = '0;
      if (model_cfg.check_enable) begin
         if (!model_seen[h.pid]) begin
            known = h.es ||
                    h.pid == PID_PAT || h.pid == PID_CAT || h.pid == PID_SDT ||
                    h.pid == PID_EIT || h.pid == PID_TDT ||
                    {3'b000, h.pid} == model_cfg.nit_pid ||
                    {3'b000, h.pid} == model_cfg.pmt_pid ||
                    {3'b000, h.pid} == model_cfg.pcr_pid ||
                    {3'b000, h.pid} == model_cfg.emm_pid ||
                    {3'b000, h.pid} == model_cfg.ecm_pid;
            if (known) begin
               model_seen[h.pid] = 1'b1;
               last_cc[h.pid]    = h.cnt;
               ev.kind           = EV_NEW;
            end
         end else begin
            // seen PID is checked even if it is no longer known
            last        = last_cc[h.pid];
            ev.expected = last + 4'd1;
            if (h.cnt == last || h.cnt == ev.expected) begin
               ev.kind = EV_IN_SEQ;
            end else begin
               ev.kind = EV_DISCONT;
               ev.gap  = h.cnt - ev.expected;
            end
            last_cc[h.pid] = h.cnt;
         end
      end
      return ev;
   endfunction

   // request side: feed queued headers, predict on each transaction
   always @(posedge clock) begin : pkt_driver
      int            send_gap;
      cc_check_type  chk;
      ts_header_type on_wire;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
         hdr_pending = 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            chk.hdr = on_wire;
            chk.ev  = predict_cc_event(on_wire);
            cc_checks_due.push_back(chk);
            packets_sent++;
            hdr_pending = 1'b0;
         end
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (headers_to_send.size() > 0) begin
            on_wire = headers_to_send.pop_front();
            hdr_pending = 1'b1;
            req_tdata  <= {7'b0, on_wire.cnt, on_wire.pid};
            req_tuser  <= on_wire.es;
            req_tvalid <= 1'b1;
            send_gap = pick_idle();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response side: random stalls, compare each transaction
   always @(posedge clock) begin : evt_monitor
      int           stall_left;
      cc_check_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            kind_seen[rsp_tuser]++;
            if (cc_checks_due.size() == 0) begin
               report_mismatch($sformatf("unexpected event kind %0d exp %0d gap %0d",
                                         rsp_tuser, rsp_tdata[3:0], rsp_tdata[7:4]));
            end else begin
               want = cc_checks_due.pop_front();
               if (rsp_tuser !== want.ev.kind)
                  report_mismatch($sformatf("pid %h cnt %0d: kind %0d, want %s",
                                            want.hdr.pid, want.hdr.cnt, rsp_tuser,
                                            want.ev.kind.name()));
               if (rsp_tdata[3:0] !== want.ev.expected)
                  report_mismatch($sformatf("pid %h cnt %0d: expected counter %0d, want %0d",
                                            want.hdr.pid, want.hdr.cnt, rsp_tdata[3:0],
                                            want.ev.expected));
               if (rsp_tdata[7:4] !== want.ev.gap)
                  report_mismatch($sformatf("pid %h cnt %0d: gap %0d, want %0d",
                                            want.hdr.pid, want.hdr.cnt, rsp_tdata[7:4],
                                            want.ev.gap));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = pick_idle();
         end
      end
   end

   // one register write; the predictor copy follows at once since the block is idle
   task automatic write_reg(input logic [CSR_AW-1:0] idx, input logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      unique case (idx)
         CSR_CHECK_ENABLE: model_cfg.check_enable = value[0];
         CSR_NIT_PID:      model_cfg.nit_pid      = value;
         CSR_PMT_PID:      model_cfg.pmt_pid      = value;
         CSR_PCR_PID:      model_cfg.pcr_pid      = value;
         CSR_EMM_PID:      model_cfg.emm_pid      = value;
         CSR_ECM_PID:      model_cfg.ecm_pid      = value;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // write all registers and rebuild the live PID pool around them
   task automatic apply_settings(input logic en, input logic [CFG_W-1:0] nit,
                                 input logic [CFG_W-1:0] pmt, input logic [CFG_W-1:0] pcr,
                                 input logic [CFG_W-1:0] emm, input logic [CFG_W-1:0] ecm);
      logic [CFG_W-1:0] cfg_pids [5];
      logic [PID_W-1:0] p;
      int               k;
      write_reg(CSR_CHECK_ENABLE, {15'b0, en});
      write_reg(CSR_NIT_PID, nit);
      write_reg(CSR_PMT_PID, pmt);
      write_reg(CSR_PCR_PID, pcr);
      write_reg(CSR_EMM_PID, emm);
      write_reg(CSR_ECM_PID, ecm);
      settings_used++;
      cfg_pids = '{nit, pmt, pcr, emm, ecm};
      live_pids.delete();
      es_stream = '{default: 1'b0};
      live_pids = '{PID_PAT, PID_CAT, PID_SDT, PID_EIT, PID_TDT};
      for (k = 0; k < 5; k++)
         if (cfg_pids[k] < PID_COUNT_DEF)
            live_pids.push_back(cfg_pids[k][PID_W-1:0]);
      for (k = 0; k < 6; k++) begin
         p = PID_W'($urandom_range(0, PID_COUNT_DEF - 1));
         es_stream[p] = 1'b1;
         live_pids.push_back(p);
      end
   endtask

   task automatic queue_header(input logic [PID_W-1:0] pid, input logic [CNT_W-1:0] cnt,
                               input logic es);
      ts_header_type h;
      h.pid = pid;
      h.cnt = cnt;
      h.es  = es;
      sent_cc[pid] = cnt;
      headers_to_send.push_back(h);
   endtask

   // mostly well-formed counter runs on live PIDs, the rest noise
   task automatic queue_random_packets(input int count);
      logic [PID_W-1:0] pid;
      logic [CNT_W-1:0] cnt;
      logic             es;
      int               r;
      int               k;
      for (k = 0; k < count; k++) begin
         if ($urandom_range(0, 99) < 80) begin
            pid = live_pids[$urandom_range(0, live_pids.size() - 1)];
            es  = es_stream[pid] ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 9) == 0);
            r   = $urandom_range(0, 99);
            if (r < 70)
               cnt = sent_cc[pid] + 4'd1;
            else if (r < 82)
               cnt = sent_cc[pid];
            else
               cnt = CNT_W'($urandom);
         end else begin
            pid = PID_W'($urandom);
            cnt = CNT_W'($urandom);
            es  = ($urandom_range(0, 3) == 0);
         end
         queue_header(pid, cnt, es);
      end
   endtask

   // sender holds off until every expected event has come back
   task automatic wait_idle();
      while (headers_to_send.size() != 0 || hdr_pending || cc_checks_due.size() != 0)
         @(posedge clock);
   endtask

   // stimulus sequence
   initial begin : stimulus
      int               ph;
      logic [CFG_W-1:0] nit, pmt, pcr, emm, ecm;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings: checking off, everything ignored
      queue_header(13'h0000, 4'd0, 1'b0);
      queue_header(13'h0010, 4'd3, 1'b0);
      queue_header(13'h1fff, 4'd15, 1'b1);
      wait_idle();

      // directed: fixed and configured PIDs, repeat, wrap, jumps
      apply_settings(1'b1, 16'h0010, 16'h1fff, 16'hffff, 16'h0020, 16'h0000);
      queue_header(PID_PAT, 4'd0, 1'b0);
      queue_header(PID_PAT, 4'd1, 1'b0);
      queue_header(PID_PAT, 4'd1, 1'b0);     // repeated counter
      queue_header(PID_PAT, 4'd5, 1'b0);     // jump ahead
      queue_header(PID_CAT, 4'd15, 1'b0);
      queue_header(PID_CAT, 4'd0, 1'b0);     // counter wrap
      queue_header(PID_SDT, 4'd3, 1'b0);
      queue_header(PID_SDT, 4'd2, 1'b0);     // step back, largest gap
      queue_header(PID_EIT, 4'd7, 1'b0);
      queue_header(PID_TDT, 4'd8, 1'b0);
      queue_header(13'h0010, 4'd0, 1'b0);    // nit
      queue_header(13'h1fff, 4'd15, 1'b0);   // pmt at top PID
      queue_header(13'h1fff, 4'd0, 1'b0);
      queue_header(13'h0020, 4'd9, 1'b0);    // emm
      queue_header(13'h0100, 4'd4, 1'b0);    // unknown, unseen
      queue_header(13'h0100, 4'd4, 1'b1);    // elementary stream
      queue_header(13'h0100, 4'd5, 1'b0);    // seen, flag gone
      queue_header(13'h1555, 4'd10, 1'b1);
      queue_header(13'h0aaa, 4'd5, 1'b1);
      queue_header(13'h0aaa, 4'd10, 1'b1);
      queue_header(13'h1fff, 4'd15, 1'b0);
      wait_idle();

      // random phases, one register setting each
      for (ph = 0; ph < 7; ph++) begin
         nit = CFG_W'($urandom_range(0, PID_COUNT_DEF - 1));
         pmt = CFG_W'($urandom_range(0, PID_COUNT_DEF - 1));
         pcr = CFG_W'($urandom_range(0, PID_COUNT_DEF - 1));
         emm = CFG_W'($urandom_range(0, PID_COUNT_DEF - 1));
         ecm = CFG_W'($urandom_range(0, PID_COUNT_DEF - 1));
         unique case (ph)
            0: begin
               pcr = 16'hffff;
               emm = 16'h0000;
               ecm = 16'h1fff;
            end
            1: begin
               nit = CFG_W'($urandom);
               pmt = CFG_W'($urandom);
               pcr = CFG_W'($urandom);
               emm = CFG_W'($urandom);
               ecm = CFG_W'($urandom);
            end
            2: begin
               nit = 16'hffff;
               pmt = 16'hffff;
               pcr = 16'hffff;
               emm = 16'hffff;
               ecm = 16'hffff;
            end
            default: ;
         endcase
         no_idle = (ph == 5);
         apply_settings(ph != 3, nit, pmt, pcr, emm, ecm);
         queue_random_packets(ph == 3 ? 30 : 135);
         wait_idle();
      end
      no_idle = 1'b0;

      repeat (8) @(posedge clock);
      if (cc_checks_due.size() != 0)
         report_mismatch($sformatf("%0d events never arrived", cc_checks_due.size()));
      $display("tb: %0d packet headers over %0d register settings", packets_sent,
               settings_used);
      $display("tb: events ignored %0d, new %0d, in sequence %0d, discontinuity %0d",
               kind_seen[EV_IGNORED], kind_seen[EV_NEW], kind_seen[EV_IN_SEQ],
               kind_seen[EV_DISCONT]);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
